/* hdl/power_basis_curve_3d_eval_top_assert.svh */
// Assertion macros used by the curve evaluator controller.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef POWER_BASIS_CURVE_3D_EVAL_TOP_ASSERT_SVH
`define POWER_BASIS_CURVE_3D_EVAL_TOP_ASSERT_SVH

// Same-cycle implication, switched off during reset.
`define PBC3D_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pbc3d: same-cycle check failed");

// Next-cycle implication, switched off during reset.
`define PBC3D_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pbc3d: next-cycle check failed");

`endif

/* hdl/pbc3d_pkg.sv */
// Shared types, constants and helpers for the 3D power-basis curve evaluator.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package pbc3d_pkg;

   // Fixed field widths.
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 7;
   localparam int CCOUNT_W  = 5;
   localparam int CIDX_W    = 4;
   localparam int OPC_W     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_LANES = 3;

   // Opcodes.
   localparam logic [OPC_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPC_W-1:0] OP_EVAL  = 2'd1;
   localparam logic [OPC_W-1:0] OP_SWEEP = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_START = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_END   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEFF_COUNT    = 2'd2;

   // Register reset values.
   localparam logic [DATA_W-1:0] START_RESET = 32'h0000_0000;
   localparam logic [DATA_W-1:0] END_RESET   = 32'h0001_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV,
      ST_SET_U,
      ST_RD_TOP,
      ST_ACC_TOP,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic store_we;
      logic div_start;
      logic set_u;
      logic use_param;
      logic rd_top;
      logic acc_top;
      logic mul;
      logic add;
      logic emit;
      logic last;
      logic pt_next;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic cnt_zero;
      logic cnt_one;
      logic n_zero;
      logic k_zero;
      logic k_one;
      logic pt_last;
      logic div_done;
   } ctrl_status_type;

   // Saturate a signed 64-bit value to 32 bits.
   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/pbc3d_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pbc3d_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                 wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

/* hdl/pbc3d_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// No dependencies.
`default_nettype none

module pbc3d_div #(
   parameter int DW = 33,
   parameter int VW = 7
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               done,
   output logic [DW-1:0]      quotient,
   output logic [VW-1:0]      remainder
);

   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] quo_ff, quo_in;
   logic [VW-1:0] rem_ff, rem_in;
   logic [VW-1:0] dvs_ff, dvs_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [VW:0]   trial;
   logic [VW:0]   trial_sub;
   logic          trial_ge;

   // One restoring step: bring down the next dividend bit and try the subtract.
   always_comb begin
      trial     = {rem_ff, quo_ff[DW-1]};
      trial_ge  = trial >= {1'b0, dvs_ff};
      trial_sub = trial - {1'b0, dvs_ff};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CW'(DW);
         run_in = 1'b1;
      end else if (run_ff) begin
         quo_in = {quo_ff[DW-2:0], trial_ge};
         rem_in = trial_ge ? trial_sub[VW-1:0] : trial[VW-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

/* hdl/pbc3d_datapath.sv */
// Datapath of the curve evaluator: registers, coefficient store, sweep stepper
// and three Horner lanes. Depends on pbc3d_pkg, pbc3d_ram and pbc3d_div.
`default_nettype none

module pbc3d_datapath #(
   parameter int MAX_COEFFS = 16,
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire pbc3d_pkg::ctrl_cmd_type                cmd,
   output pbc3d_pkg::ctrl_status_type                  status,
   input  wire logic [pbc3d_pkg::CIDX_W-1:0]           req_coeff_index,
   input  wire logic signed [pbc3d_pkg::DATA_W-1:0]    req_coeff_x,
   input  wire logic signed [pbc3d_pkg::DATA_W-1:0]    req_coeff_y,
   input  wire logic signed [pbc3d_pkg::DATA_W-1:0]    req_coeff_z,
   input  wire logic signed [pbc3d_pkg::DATA_W-1:0]    req_param_u,
   input  wire logic [pbc3d_pkg::CNT_W-1:0]            req_num_points,
   input  wire logic                                   csr_write_enable,
   input  wire logic [pbc3d_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [pbc3d_pkg::DATA_W-1:0]           csr_write_data,
   output logic                                        rsp_valid,
   output logic signed [pbc3d_pkg::DATA_W-1:0]         rsp_point_x,
   output logic signed [pbc3d_pkg::DATA_W-1:0]         rsp_point_y,
   output logic signed [pbc3d_pkg::DATA_W-1:0]         rsp_point_z,
   output logic signed [pbc3d_pkg::DATA_W-1:0]         rsp_param_used,
   output logic                                        rsp_last_point
);

   localparam int DW   = pbc3d_pkg::DATA_W;
   localparam int NL   = pbc3d_pkg::NUM_LANES;
   localparam int CW   = pbc3d_pkg::CNT_W;
   localparam int NW   = pbc3d_pkg::CCOUNT_W;
   localparam int IW   = pbc3d_pkg::CIDX_W;
   localparam int AW   = (MAX_COEFFS > 1) ? $clog2(MAX_COEFFS) : 1;
   localparam int RXW  = (AW > NW) ? AW : NW;
   localparam int WXW  = (AW > IW) ? AW : IW;
   localparam int QW   = DW + 1;
   localparam int SUMW = DW + 2;

   // Configuration registers.
   logic [DW-1:0] start_ff, start_in;
   logic [DW-1:0] end_ff, end_in;
   logic [NW-1:0] ccount_ff, ccount_in;

   always_comb begin
      start_in  = start_ff;
      end_in    = end_ff;
      ccount_in = ccount_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            pbc3d_pkg::CSR_INTERVAL_START: start_in  = csr_write_data;
            pbc3d_pkg::CSR_INTERVAL_END:   end_in    = csr_write_data;
            pbc3d_pkg::CSR_COEFF_COUNT:    ccount_in = csr_write_data[NW-1:0];
            default:                       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= pbc3d_pkg::START_RESET;
         end_ff    <= pbc3d_pkg::END_RESET;
         ccount_ff <= '0;
      end else begin
         start_ff  <= start_in;
         end_ff    <= end_in;
         ccount_ff <= ccount_in;
      end
   end

   // Coefficients in use, clipped to the store depth.
   logic [NW-1:0] n_eff;
   assign n_eff = (int'(ccount_ff) > MAX_COEFFS) ? NW'(MAX_COEFFS) : ccount_ff;

   // Item registers captured on acceptance.
   logic signed [DW-1:0] param_ff, param_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   always_comb begin
      param_in = param_ff;
      cnt_in   = cnt_ff;
      if (cmd.capture) begin
         param_in = req_param_u;
         cnt_in   = (int'(req_num_points) > MAX_POINTS) ? CW'(MAX_POINTS)
                                                        : req_num_points;
      end
   end

   always_ff @(posedge clock) begin
      param_ff <= param_in;
      cnt_ff   <= cnt_in;
   end

   // Coefficient store: x, y and z side by side in one word.
   logic [NW-1:0]        k_ff, k_in;
   logic [NW-1:0]        rd_idx;
   logic [RXW-1:0]       rd_wide;
   logic [WXW-1:0]       wr_wide;
   logic [AW-1:0]        raddr;
   logic [AW-1:0]        waddr;
   logic                 store_we;
   logic [NL*DW-1:0]     store_wdata;
   logic [NL*DW-1:0]     store_rdata;

   assign rd_idx      = cmd.rd_top ? (n_eff - 1'b1) : (k_ff - 1'b1);
   assign rd_wide     = RXW'(rd_idx);
   assign raddr       = rd_wide[AW-1:0];
   assign wr_wide     = WXW'(req_coeff_index);
   assign waddr       = wr_wide[AW-1:0];
   assign store_we    = cmd.store_we && (int'(req_coeff_index) < MAX_COEFFS);
   assign store_wdata = {req_coeff_z, req_coeff_y, req_coeff_x};

   pbc3d_ram #(
      .WIDTH(NL * DW),
      .DEPTH(MAX_COEFFS)
   ) u_store (
      .clock(clock),
      .we   (store_we),
      .waddr(waddr),
      .wdata(store_wdata),
      .raddr(raddr),
      .rdata(store_rdata)
   );

   // Sweep spacing: |end - start| divided once by count - 1.
   logic signed [DW:0]   diff;
   logic [QW-1:0]        diff_mag;
   logic                 diff_neg;
   logic [CW-1:0]        dvs;
   logic                 div_done;
   logic [QW-1:0]        quo;
   logic [CW-1:0]        rem;

   assign diff     = (DW + 1)'($signed(end_ff)) - (DW + 1)'($signed(start_ff));
   assign diff_neg = diff[DW];
   assign diff_mag = diff_neg ? QW'(-diff) : QW'(diff);
   assign dvs      = cnt_ff - 1'b1;

   pbc3d_div #(
      .DW(QW),
      .VW(CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (diff_mag),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (quo),
      .remainder(rem)
   );

   // Point stepper: offset_i = i*Q + floor(i*R / d), remainder kept below d.
   // The offset never exceeds |end - start|, so it fits the divider width.
   logic [QW-1:0]        off_ff, off_in;
   logic [CW-1:0]        frac_ff, frac_in;
   logic [CW-1:0]        pidx_ff, pidx_in;
   logic [CW:0]          frac_sum;
   logic [CW:0]          frac_red;
   logic                 frac_wrap;

   always_comb begin
      frac_sum  = {1'b0, frac_ff} + {1'b0, rem};
      frac_wrap = frac_sum >= {1'b0, dvs};
      frac_red  = frac_sum - {1'b0, dvs};
      off_in    = off_ff;
      frac_in   = frac_ff;
      pidx_in   = pidx_ff;
      if (cmd.capture) begin
         off_in  = '0;
         frac_in = '0;
         pidx_in = '0;
      end else if (cmd.pt_next) begin
         off_in  = off_ff + quo + QW'(frac_wrap);
         frac_in = frac_wrap ? frac_red[CW-1:0] : frac_sum[CW-1:0];
         pidx_in = pidx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      off_ff  <= off_in;
      frac_ff <= frac_in;
      pidx_ff <= pidx_in;
   end

   // Parameter of the current point.
   logic signed [SUMW-1:0] u_sweep;
   logic signed [DW-1:0]   u_ff, u_in;

   assign u_sweep = SUMW'($signed(start_ff))
                  + (diff_neg ? -$signed({1'b0, off_ff}) : $signed({1'b0, off_ff}));

   always_comb begin
      u_in = u_ff;
      if (cmd.set_u) begin
         u_in = cmd.use_param ? param_ff : u_sweep[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      u_ff <= u_in;
   end

   // Horner step counter.
   always_comb begin
      k_in = k_ff;
      if (cmd.rd_top) begin
         k_in = n_eff - 1'b1;
      end else if (cmd.add) begin
         k_in = k_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      k_ff <= k_in;
   end

   // Horner lanes: multiply into a register, then shift, saturate and add.
   logic signed [DW-1:0]   acc_ff [NL];
   logic signed [DW-1:0]   acc_in [NL];
   logic signed [2*DW-1:0] prod_ff [NL];
   logic signed [2*DW-1:0] prod_in [NL];
   logic signed [DW-1:0]   coef [NL];
   logic signed [2*DW-1:0] prod_sh [NL];
   logic signed [DW-1:0]   prod_sat [NL];
   logic signed [DW:0]     lane_sum [NL];

   always_comb begin
      for (int j = 0; j < NL; j++) begin
         coef[j]     = store_rdata[j*DW +: DW];
         prod_in[j]  = cmd.mul ? (u_ff * acc_ff[j]) : prod_ff[j];
         prod_sh[j]  = prod_ff[j] >>> FRAC_BITS;
         prod_sat[j] = pbc3d_pkg::sat32(prod_sh[j]);
         lane_sum[j] = (DW + 1)'(prod_sat[j]) + (DW + 1)'(coef[j]);
         acc_in[j]   = acc_ff[j];
         if (cmd.acc_top) begin
            acc_in[j] = status.n_zero ? '0 : coef[j];
         end else if (cmd.add) begin
            acc_in[j] = pbc3d_pkg::sat32(64'(lane_sum[j]));
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < NL; j++) begin
         acc_ff[j]  <= acc_in[j];
         prod_ff[j] <= prod_in[j];
      end
   end

   // Result registers: the strobe lasts one cycle per result.
   logic                 valid_ff;
   logic signed [DW-1:0] px_ff, py_ff, pz_ff, pu_ff;
   logic                 last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         px_ff   <= acc_ff[0];
         py_ff   <= acc_ff[1];
         pz_ff   <= acc_ff[2];
         pu_ff   <= u_ff;
         last_ff <= cmd.last;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_point_x    = px_ff;
   assign rsp_point_y    = py_ff;
   assign rsp_point_z    = pz_ff;
   assign rsp_param_used = pu_ff;
   assign rsp_last_point = last_ff;

   // Status back to the controller.
   always_comb begin
      status.cnt_zero = (cnt_ff == '0);
      status.cnt_one  = (cnt_ff == CW'(1));
      status.n_zero   = (n_eff == '0);
      status.k_zero   = (k_ff == '0);
      status.k_one    = (k_ff == NW'(1));
      status.pt_last  = (pidx_ff == dvs);
      status.div_done = div_done;
   end

endmodule

`default_nettype wire

/* hdl/pbc3d_ctrl.sv */
// Controller state machine of the curve evaluator: sequences loads, the sweep
// divide, the Horner steps and result strobes. Depends on pbc3d_pkg and power_basis_curve_3d_eval_top_assert.svh.
`default_nettype none

`include "power_basis_curve_3d_eval_top_assert.svh"

module pbc3d_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [pbc3d_pkg::OPC_W-1:0]    req_opcode,
   output logic                                busy,
   output pbc3d_pkg::ctrl_cmd_type             cmd,
   input  wire pbc3d_pkg::ctrl_status_type     status
);

   pbc3d_pkg::state_type              state_ff, state_in;
   logic [pbc3d_pkg::OPC_W-1:0]       op_ff, op_in;
   logic                              accept;
   logic                              is_eval;

   assign busy    = (state_ff != pbc3d_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign is_eval = (op_ff == pbc3d_pkg::OP_EVAL);

   // State and opcode registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbc3d_pkg::ST_IDLE;
         op_ff    <= pbc3d_pkg::OP_LOAD;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd      = '0;
      unique case (state_ff)
         pbc3d_pkg::ST_IDLE: begin
            if (start) begin
               cmd.capture  = 1'b1;
               cmd.store_we = (req_opcode == pbc3d_pkg::OP_LOAD);
               op_in        = req_opcode;
               state_in     = pbc3d_pkg::ST_DECODE;
            end
         end
         pbc3d_pkg::ST_DECODE: begin
            priority if (op_ff == pbc3d_pkg::OP_EVAL) begin
               state_in = pbc3d_pkg::ST_SET_U;
            end else if (op_ff == pbc3d_pkg::OP_SWEEP) begin
               priority if (status.cnt_zero) begin
                  state_in = pbc3d_pkg::ST_IDLE;
               end else if (status.cnt_one) begin
                  state_in = pbc3d_pkg::ST_SET_U;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = pbc3d_pkg::ST_DIV;
               end
            end else begin
               // Loads finished on acceptance; the unused opcode does nothing.
               state_in = pbc3d_pkg::ST_IDLE;
            end
         end
         pbc3d_pkg::ST_DIV: begin
            if (status.div_done) begin
               state_in = pbc3d_pkg::ST_SET_U;
            end
         end
         pbc3d_pkg::ST_SET_U: begin
            cmd.set_u     = 1'b1;
            cmd.use_param = is_eval;
            state_in      = pbc3d_pkg::ST_RD_TOP;
         end
         pbc3d_pkg::ST_RD_TOP: begin
            cmd.rd_top = 1'b1;
            state_in   = pbc3d_pkg::ST_ACC_TOP;
         end
         pbc3d_pkg::ST_ACC_TOP: begin
            cmd.acc_top = 1'b1;
            if (status.n_zero || status.k_zero) begin
               state_in = pbc3d_pkg::ST_EMIT;
            end else begin
               state_in = pbc3d_pkg::ST_MUL;
            end
         end
         pbc3d_pkg::ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = pbc3d_pkg::ST_ADD;
         end
         pbc3d_pkg::ST_ADD: begin
            cmd.add = 1'b1;
            if (status.k_one) begin
               state_in = pbc3d_pkg::ST_EMIT;
            end else begin
               state_in = pbc3d_pkg::ST_MUL;
            end
         end
         pbc3d_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.last = is_eval || status.pt_last;
            if (cmd.last) begin
               state_in = pbc3d_pkg::ST_IDLE;
            end else begin
               cmd.pt_next = 1'b1;
               state_in    = pbc3d_pkg::ST_SET_U;
            end
         end
         default: begin
            state_in = pbc3d_pkg::ST_IDLE;
         end
      endcase
   end

   // An accepted item always makes the block busy in the following cycle.
   `PBC3D_ASSERT_NEXT(a_accept_busy, accept, busy)
   // The divider only finishes while the controller waits for it.
   `PBC3D_ASSERT_IMPL(a_div_done_in_div, status.div_done, state_ff == pbc3d_pkg::ST_DIV)
   // Two results are never emitted in consecutive cycles.
   `PBC3D_ASSERT_NEXT(a_emit_spaced, cmd.emit, !cmd.emit)
   // Stepping to the next sweep point only happens for a sweep.
   `PBC3D_ASSERT_IMPL(a_step_sweep_only, cmd.pt_next, op_ff == pbc3d_pkg::OP_SWEEP)

endmodule

`default_nettype wire

/* hdl/power_basis_curve_3d_eval_top.sv */
// Top level of the 3D power-basis curve evaluator (Horner's rule, Q16.16).
// Depends on pbc3d_pkg, pbc3d_ctrl and pbc3d_datapath.
//
//   Channel   Ports                      Handshake
//   --------  -------------------------  ---------------------------------------
//   request   start, busy, req_*         item taken when start high, busy low
//   result    rsp_valid, rsp_*           one-cycle strobe, never held off
//   config    csr_write_enable, csr_*    written on any edge with enable high
//
// A load, an unused opcode or an empty sweep returns to idle straight after decode. An
// evaluation runs a fixed setup, then one multiply-add per coefficient below the top
// one, then the result strobe. A sweep of more than one point first runs the
// bit-serial divide that sets the spacing, then repeats these steps for each point; a
// sweep of one point takes the same path as an evaluation.
// Reset is synchronous and active high; the coefficient store is not cleared.
// The receiver cannot stall: each result is marked valid on rsp_valid for exactly one cycle.
`default_nettype none

module power_basis_curve_3d_eval_top #(
   parameter int MAX_COEFFS = 16,
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic [pbc3d_pkg::OPC_W-1:0]          req_opcode,
   input  wire logic [pbc3d_pkg::CIDX_W-1:0]         req_coeff_index,
   input  wire logic signed [pbc3d_pkg::DATA_W-1:0]  req_coeff_x,
   input  wire logic signed [pbc3d_pkg::DATA_W-1:0]  req_coeff_y,
   input  wire logic signed [pbc3d_pkg::DATA_W-1:0]  req_coeff_z,
   input  wire logic signed [pbc3d_pkg::DATA_W-1:0]  req_param_u,
   input  wire logic [pbc3d_pkg::CNT_W-1:0]          req_num_points,
   output logic                                      rsp_valid,
   output logic signed [pbc3d_pkg::DATA_W-1:0]       rsp_point_x,
   output logic signed [pbc3d_pkg::DATA_W-1:0]       rsp_point_y,
   output logic signed [pbc3d_pkg::DATA_W-1:0]       rsp_point_z,
   output logic signed [pbc3d_pkg::DATA_W-1:0]       rsp_param_used,
   output logic                                      rsp_last_point,
   input  wire logic                                 csr_write_enable,
   input  wire logic [pbc3d_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pbc3d_pkg::DATA_W-1:0]         csr_write_data
);

   pbc3d_pkg::ctrl_cmd_type    cmd;
   pbc3d_pkg::ctrl_status_type status;

   // Controller.
   pbc3d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_opcode(req_opcode),
      .busy      (busy),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath.
   pbc3d_datapath #(
      .MAX_COEFFS(MAX_COEFFS),
      .MAX_POINTS(MAX_POINTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_coeff_index (req_coeff_index),
      .req_coeff_x     (req_coeff_x),
      .req_coeff_y     (req_coeff_y),
      .req_coeff_z     (req_coeff_z),
      .req_param_u     (req_param_u),
      .req_num_points  (req_num_points),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .rsp_valid       (rsp_valid),
      .rsp_point_x     (rsp_point_x),
      .rsp_point_y     (rsp_point_y),
      .rsp_point_z     (rsp_point_z),
      .rsp_param_used  (rsp_param_used),
      .rsp_last_point  (rsp_last_point)
   );

endmodule

`default_nettype wire
